@@ hw/rtl/riffwav_pkg.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Chunk tags, result kinds and error codes shared by the parser.
// ----------------------------------------------------------------------------
package riffwav_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] RIFF_TAG_END    = 32'd4;
    localparam logic [31:0] RIFF_HEADER_END = 32'd12;
    localparam logic [31:0] CHUNK_HDR_LEN   = 32'd8;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_ERROR  = 2'd3
    } t_result_kind;

    typedef enum logic [1:0] {
        ERR_RIFF_TAG       = 2'd0,
        ERR_WAVE_TAG       = 2'd1,
        ERR_BODY_EXHAUSTED = 2'd2,
        ERR_TRUNCATED      = 2'd3
    } t_error_code;

endpackage

@@ hw/rtl/riff_wave_chunk_parser.sv @@
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Checks the RIFF/WAVE header, walks chunks, captures the fmt fields and
// passes out data chunk bytes.
// ----------------------------------------------------------------------------
// The parser takes one byte of a WAVE file per item and sustains one item per
// clock cycle while the output is not stalled. An item passes an input register,
// is decoded by the combinational per-byte header and chunk logic, and its
// result, if any, is registered in the output register. A result that
// waits on a stalled output does not block the input register until a second
// item is also waiting. An item with end_of_file set returns the parser to the
// start of the RIFF header search.
module riff_wave_chunk_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_byte_value,
    input  logic                      i_end_of_file,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output riffwav_pkg::t_result_kind o_result_kind,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last_payload,
    output logic [15:0]               o_channel_count,
    output logic [31:0]               o_sample_rate,
    output logic [15:0]               o_bits_per_sample,
    output logic [31:0]               o_data_length,
    output logic                      o_file_complete,
    output riffwav_pkg::t_error_code  o_error_code
);
    import riffwav_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_PAD,
        PH_IDLE
    } t_phase;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_eof;

    t_phase       r_phase,        n_phase;
    logic [31:0]  r_byte_position, n_byte_position;
    logic [31:0]  r_chunk_tag,    n_chunk_tag;
    logic [31:0]  r_chunk_length, n_chunk_length;
    logic [32:0]  r_body_left,    n_body_left;
    logic         r_fmt_seen,     n_fmt_seen;
    logic         r_data_seen,    n_data_seen;
    logic [15:0]  r_channels,     n_channels;
    logic [31:0]  r_rate,         n_rate;
    logic [15:0]  r_sample_bits,  n_sample_bits;
    logic [31:0]  r_data_length,  n_data_length;

    logic         r_out_valid;
    t_result_kind r_out_kind,     n_res_kind;
    logic [7:0]   r_out_byte,     n_res_byte;
    logic         r_out_last,     n_res_last;
    logic [15:0]  r_out_channels, n_res_channels;
    logic [31:0]  r_out_rate,     n_res_rate;
    logic [15:0]  r_out_bits,     n_res_bits;
    logic [31:0]  r_out_dlen,     n_res_dlen;
    logic         r_out_done,     n_res_done;
    t_error_code  r_out_err,      n_res_err;
    logic         n_res_valid;

    logic         out_free;
    logic         advance;
    logic         accept;
    logic [31:0]  pos;
    logic [31:0]  pos_inc;
    logic [31:0]  byte_lane;
    logic [32:0]  used;
    logic         fin_req;
    logic         fin_fmt;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign pos       = r_byte_position;
    assign pos_inc   = r_byte_position + 32'd1;
    assign byte_lane = {24'd0, r_in_byte} << {pos[1:0], 3'b000};

    always_comb begin
        n_phase         = r_phase;
        n_byte_position = r_byte_position;
        n_chunk_tag     = r_chunk_tag;
        n_chunk_length  = r_chunk_length;
        n_body_left     = r_body_left;
        n_fmt_seen      = r_fmt_seen;
        n_data_seen     = r_data_seen;
        n_channels      = r_channels;
        n_rate          = r_rate;
        n_sample_bits   = r_sample_bits;
        n_data_length   = r_data_length;

        n_res_valid    = 1'b0;
        n_res_kind     = KIND_DATA;
        n_res_byte     = 8'd0;
        n_res_last     = 1'b0;
        n_res_channels = 16'd0;
        n_res_rate     = 32'd0;
        n_res_bits     = 16'd0;
        n_res_dlen     = 32'd0;
        n_res_done     = 1'b0;
        n_res_err      = ERR_RIFF_TAG;
        fin_req        = 1'b0;
        fin_fmt        = 1'b0;
        used           = 33'd0;

        if (r_in_eof) begin
            if (r_phase == PH_IDLE || (r_phase == PH_RIFF && pos == 32'd0)) begin
                n_res_valid = 1'b0;
            end else if (r_phase == PH_HDR && pos == 32'd0 && r_body_left == 33'd0) begin
                n_res_valid = 1'b1;
                n_res_kind  = KIND_ERROR;
                n_res_err   = ERR_BODY_EXHAUSTED;
            end else begin
                n_res_valid = 1'b1;
                n_res_kind  = KIND_ERROR;
                n_res_err   = ERR_TRUNCATED;
            end
            n_phase         = PH_RIFF;
            n_byte_position = 32'd0;
            n_chunk_tag     = 32'd0;
            n_chunk_length  = 32'd0;
            n_body_left     = 33'd0;
            n_fmt_seen      = 1'b0;
            n_data_seen     = 1'b0;
            n_channels      = 16'd0;
            n_rate          = 32'd0;
            n_sample_bits   = 16'd0;
            n_data_length   = 32'd0;
        end else begin
            unique case (r_phase)
                PH_RIFF: begin
                    if (pos < 32'd4 || pos >= 32'd8) begin
                        n_chunk_tag = {r_chunk_tag[23:0], r_in_byte};
                    end else begin
                        n_chunk_length = r_chunk_length | byte_lane;
                    end
                    n_byte_position = pos_inc;
                    if (pos_inc == RIFF_TAG_END && n_chunk_tag != TAG_RIFF) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = KIND_ERROR;
                        n_res_err   = ERR_RIFF_TAG;
                        n_phase     = PH_IDLE;
                    end else if (pos_inc == RIFF_HEADER_END) begin
                        if (n_chunk_tag != TAG_WAVE) begin
                            n_res_valid = 1'b1;
                            n_res_kind  = KIND_ERROR;
                            n_res_err   = ERR_WAVE_TAG;
                            n_phase     = PH_IDLE;
                        end else begin
                            n_body_left = (n_chunk_length >= 32'd4) ?
                                          {1'b0, n_chunk_length - 32'd4} : 33'd0;
                            n_phase         = PH_HDR;
                            n_byte_position = 32'd0;
                            n_chunk_tag     = 32'd0;
                            n_chunk_length  = 32'd0;
                        end
                    end
                end
                PH_HDR: begin
                    if (pos == 32'd0 && r_body_left == 33'd0) begin
                        n_res_valid = 1'b1;
                        n_res_kind  = KIND_ERROR;
                        n_res_err   = ERR_BODY_EXHAUSTED;
                        n_phase     = PH_IDLE;
                    end else begin
                        if (pos < 32'd4) begin
                            n_chunk_tag = {r_chunk_tag[23:0], r_in_byte};
                        end else begin
                            n_chunk_length = r_chunk_length | byte_lane;
                        end
                        n_byte_position = pos_inc;
                        if (pos_inc >= CHUNK_HDR_LEN) begin
                            used = {1'b0, n_chunk_length} + 33'd8 + {32'd0, n_chunk_length[0]};
                            n_body_left = (r_body_left > used) ? (r_body_left - used) : 33'd0;
                            n_byte_position = 32'd0;
                            if (n_chunk_tag == TAG_FMT) begin
                                n_phase = PH_FMT;
                                if (n_chunk_length == 32'd0) begin
                                    fin_req     = 1'b1;
                                    fin_fmt     = 1'b1;
                                    n_res_valid = 1'b1;
                                    n_res_kind  = KIND_FORMAT;
                                end
                            end else if (n_chunk_tag == TAG_DATA) begin
                                n_phase       = PH_DATA;
                                n_data_length = n_chunk_length;
                                if (n_chunk_length == 32'd0) begin
                                    fin_req     = 1'b1;
                                    n_res_valid = 1'b1;
                                    n_res_kind  = KIND_EMPTY;
                                end
                            end else begin
                                n_phase = PH_SKIP;
                                if (n_chunk_length == 32'd0) begin
                                    n_phase        = PH_HDR;
                                    n_chunk_tag    = 32'd0;
                                end
                            end
                        end
                    end
                end
                PH_FMT: begin
                    if (pos == 32'd2) begin
                        n_channels[7:0] = r_in_byte;
                    end else if (pos == 32'd3) begin
                        n_channels[15:8] = r_in_byte;
                    end else if (pos >= 32'd4 && pos < 32'd8) begin
                        n_rate[{pos[1:0], 3'b000} +: 8] = r_in_byte;
                    end else if (pos == 32'd14) begin
                        n_sample_bits[7:0] = r_in_byte;
                    end else if (pos == 32'd15) begin
                        n_sample_bits[15:8] = r_in_byte;
                    end
                    n_byte_position = pos_inc;
                    if (pos_inc == r_chunk_length) begin
                        fin_req     = 1'b1;
                        fin_fmt     = 1'b1;
                        n_res_valid = 1'b1;
                        n_res_kind  = KIND_FORMAT;
                    end
                end
                PH_DATA: begin
                    n_byte_position = pos_inc;
                    n_res_valid     = 1'b1;
                    n_res_kind      = KIND_DATA;
                    n_res_byte      = r_in_byte;
                    n_res_dlen      = r_data_length;
                    if (pos_inc == r_chunk_length) begin
                        n_res_last = 1'b1;
                        fin_req    = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_byte_position = pos_inc;
                    if (pos_inc == r_chunk_length) begin
                        if (r_chunk_length[0]) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_phase         = PH_HDR;
                            n_byte_position = 32'd0;
                            n_chunk_tag     = 32'd0;
                            n_chunk_length  = 32'd0;
                        end
                    end
                end
                PH_PAD: begin
                    n_phase         = PH_HDR;
                    n_byte_position = 32'd0;
                    n_chunk_tag     = 32'd0;
                    n_chunk_length  = 32'd0;
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (fin_req) begin
                if (fin_fmt) begin
                    n_fmt_seen = 1'b1;
                end else begin
                    n_data_seen = 1'b1;
                end
                if (n_fmt_seen && n_data_seen) begin
                    n_phase    = PH_IDLE;
                    n_res_done = 1'b1;
                end else if (n_chunk_length[0]) begin
                    n_phase = PH_PAD;
                end else begin
                    n_phase         = PH_HDR;
                    n_byte_position = 32'd0;
                    n_chunk_tag     = 32'd0;
                    n_chunk_length  = 32'd0;
                end
            end

            if (n_res_kind == KIND_FORMAT) begin
                n_res_channels = n_channels;
                n_res_rate     = n_rate;
                n_res_bits     = n_sample_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_RIFF;
            r_byte_position <= 32'd0;
            r_chunk_tag     <= 32'd0;
            r_chunk_length  <= 32'd0;
            r_body_left     <= 33'd0;
            r_fmt_seen      <= 1'b0;
            r_data_seen     <= 1'b0;
            r_channels      <= 16'd0;
            r_rate          <= 32'd0;
            r_sample_bits   <= 16'd0;
            r_data_length   <= 32'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid     <= n_res_valid;
                r_phase         <= n_phase;
                r_byte_position <= n_byte_position;
                r_chunk_tag     <= n_chunk_tag;
                r_chunk_length  <= n_chunk_length;
                r_body_left     <= n_body_left;
                r_fmt_seen      <= n_fmt_seen;
                r_data_seen     <= n_data_seen;
                r_channels      <= n_channels;
                r_rate          <= n_rate;
                r_sample_bits   <= n_sample_bits;
                r_data_length   <= n_data_length;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_value;
            r_in_eof  <= i_end_of_file;
        end
        if (advance && n_res_valid) begin
            r_out_kind     <= n_res_kind;
            r_out_byte     <= n_res_byte;
            r_out_last     <= n_res_last;
            r_out_channels <= n_res_channels;
            r_out_rate     <= n_res_rate;
            r_out_bits     <= n_res_bits;
            r_out_dlen     <= n_res_dlen;
            r_out_done     <= n_res_done;
            r_out_err      <= n_res_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_payload_byte    = r_out_byte;
    assign o_last_payload    = r_out_last;
    assign o_channel_count   = r_out_channels;
    assign o_sample_rate     = r_out_rate;
    assign o_bits_per_sample = r_out_bits;
    assign o_data_length     = r_out_dlen;
    assign o_file_complete   = r_out_done;
    assign o_error_code      = r_out_err;

    a_complete_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res_valid && n_res_done) |=> (r_phase == PH_IDLE))
        else $error("Parser did not idle after the file completed.");

    a_error_stops_parsing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res_valid && n_res_kind == KIND_ERROR)
        |=> (r_phase == PH_IDLE || r_phase == PH_RIFF))
        else $error("Parser kept walking chunks after an error.");

    a_header_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_byte_position < CHUNK_HDR_LEN))
        else $error("Chunk header position ran past the header.");

    a_last_marks_data_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res_valid && n_res_kind == KIND_DATA && n_res_last) |=> r_data_seen)
        else $error("Final data byte did not close the data chunk.");

    a_free_output_takes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> !r_in_valid || $past(accept))
        else $error("Held item was not processed although the output was free.");

endmodule
